FILE: design/tad_pkg.sv
`timescale 1ns / 1ps

package tad_pkg;

    localparam int unsigned CODE_W = 8;
    localparam int unsigned ATTR_W = 8;
    localparam int unsigned ADDR_W = 11;
    localparam int unsigned PEN_W  = 3;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = ADDR_W;

    localparam logic [PEN_W-1:0] PEN_WHITE = 3'h7;
    localparam logic [PEN_W-1:0] PEN_BLACK = 3'h0;
    localparam logic [ATTR_W-1:0] ATTR_NONE = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FORTY_COLUMN   = 2'd0,
        CFG_CURSOR_ENABLE  = 2'd1,
        CFG_CURSOR_ADDRESS = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_KEEP     = 2'd0,
        CMD_RESERVED = 2'd1,
        CMD_BLANK    = 2'd2,
        CMD_WIDE     = 2'd3
    } attr_cmd_t;

    typedef struct packed {
        logic              row_start;
        logic [CODE_W-1:0] char_code;
        logic [ATTR_W-1:0] attr_byte;
        logic [ATTR_W-1:0] next_attr_byte;
        logic [ADDR_W-1:0] cell_address;
    } cell_in_t;

    typedef struct packed {
        logic              [CODE_W-1:0] code_out;
        logic              [ADDR_W-1:0] address_out;
        logic              [PEN_W-1:0]  foreground;
        logic              [PEN_W-1:0]  background;
        logic                           underline_on;
        logic                           blink_on;
        logic                           width_bit_low;
        logic                           width_bit_high;
        logic                           cursor_here;
    } cell_out_t;

    typedef struct packed {
        logic              forty_column;
        logic              cursor_enable;
        logic [ADDR_W-1:0] cursor_address;
    } cfg_t;

    typedef struct packed {
        logic [PEN_W-1:0] fg;
        logic [PEN_W-1:0] bg;
        logic             underline;
        logic             flash;
        logic             wide_low;
        logic             wide_high;
        logic             skip_pending;
    } attr_state_t;

    localparam attr_state_t STATE_RESET = '{
        fg:           PEN_WHITE,
        bg:           PEN_BLACK,
        underline:    1'b0,
        flash:        1'b0,
        wide_low:     1'b0,
        wide_high:    1'b0,
        skip_pending: 1'b0
    };

endpackage

FILE: design/tad_cfg_regs.sv
`timescale 1ns / 1ps

module tad_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            write_enable,
    input  logic [tad_pkg::CFG_INDEX_W-1:0] index,
    input  logic [tad_pkg::CFG_DATA_W-1:0]  data,
    output tad_pkg::cfg_t                   cfg
);

    tad_pkg::cfg_t cfg_reg;
    tad_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (tad_pkg::cfg_index_t'(index))
                tad_pkg::CFG_FORTY_COLUMN:   cfg_next.forty_column   = data[0];
                tad_pkg::CFG_CURSOR_ENABLE:  cfg_next.cursor_enable  = data[0];
                tad_pkg::CFG_CURSOR_ADDRESS: cfg_next.cursor_address =
                                                 data[tad_pkg::ADDR_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/tad_decode.sv
`timescale 1ns / 1ps

module tad_decode
(
    input  tad_pkg::cell_in_t    cur_cell,
    input  tad_pkg::cfg_t        cfg,
    input  tad_pkg::attr_state_t state,
    output tad_pkg::attr_state_t state_next,
    output logic                 emit,
    output tad_pkg::cell_out_t   result
);

    tad_pkg::attr_state_t base;
    tad_pkg::attr_state_t upd;
    tad_pkg::attr_cmd_t   cmd;
    logic                 is_command;

    assign cmd        = tad_pkg::attr_cmd_t'(cur_cell.attr_byte[7:6]);
    assign is_command = (cur_cell.attr_byte[2:0] == cur_cell.attr_byte[5:3]);

    // row start clears attributes and the pending skip first
    always_comb
    begin
        base = state;
        if (cur_cell.row_start)
        begin
            base           = tad_pkg::STATE_RESET;
            base.wide_low  = cfg.forty_column;
            base.wide_high = cfg.forty_column;
        end
    end

    always_comb
    begin
        upd = base;
        if (is_command)
        begin
            unique case (cmd) inside
                tad_pkg::CMD_KEEP, tad_pkg::CMD_RESERVED:
                begin
                    upd = base;
                end
                tad_pkg::CMD_BLANK:
                begin
                    upd.fg        = tad_pkg::PEN_BLACK;
                    upd.bg        = tad_pkg::PEN_BLACK;
                    upd.underline = 1'b0;
                    upd.flash     = 1'b0;
                end
                tad_pkg::CMD_WIDE:
                begin
                    upd.wide_low  = cur_cell.attr_byte[0];
                    upd.wide_high = cur_cell.attr_byte[1];
                    if (cur_cell.next_attr_byte != tad_pkg::ATTR_NONE)
                    begin
                        upd.fg        = cur_cell.next_attr_byte[2:0];
                        upd.bg        = cur_cell.next_attr_byte[5:3];
                        upd.underline = cur_cell.next_attr_byte[6];
                        upd.flash     = cur_cell.next_attr_byte[7];
                    end
                end
                default:
                begin
                    upd = base;
                end
            endcase
        end
        else
        begin
            upd.fg        = cur_cell.attr_byte[2:0];
            upd.bg        = cur_cell.attr_byte[5:3];
            upd.underline = cur_cell.attr_byte[6];
            upd.flash     = cur_cell.attr_byte[7];
            upd.wide_low  = cfg.forty_column;
            upd.wide_high = cfg.forty_column;
        end
        upd.skip_pending = (upd.wide_low | upd.wide_high) & ~cfg.forty_column;
    end

    // second half of a wide character on an 80-column screen is swallowed
    always_comb
    begin
        if (base.skip_pending)
        begin
            emit                    = 1'b0;
            state_next              = base;
            state_next.skip_pending = 1'b0;
        end
        else
        begin
            emit       = 1'b1;
            state_next = upd;
        end
    end

    always_comb
    begin
        result.code_out       = cur_cell.char_code;
        result.address_out    = cur_cell.cell_address;
        result.foreground     = upd.fg;
        result.background     = upd.bg;
        result.underline_on   = upd.underline;
        result.blink_on       = upd.flash;
        result.width_bit_low  = upd.wide_low;
        result.width_bit_high = upd.wide_high;
        result.cursor_here    = cfg.cursor_enable
                                && (cur_cell.cell_address == cfg.cursor_address);
    end

endmodule

FILE: design/text_attribute_decoder.sv
`timescale 1ns / 1ps

// a cell goes from in_data through cell_reg and the decode to out_data_reg
// one cell per cycle when out_stall allows; a dropped cell needs no output slot
// the attribute state advances only when the input register hands on its cell
// reset: async, rst_n low; valid and config zero, pens white on black, no skip

module text_attribute_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  tad_pkg::cell_in_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output tad_pkg::cell_out_t              out_data,
    input  logic                            cfg_write_enable,
    input  logic [tad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tad_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tad_pkg::cfg_t        cfg;
    tad_pkg::cell_in_t    cell_reg;
    logic                 cell_valid_reg;
    tad_pkg::attr_state_t state_reg;
    tad_pkg::attr_state_t state_next;
    tad_pkg::cell_out_t   out_data_reg;
    logic                 out_valid_reg;
    tad_pkg::cell_out_t   result;
    logic                 emit;
    logic                 out_free;
    logic                 cell_fire;
    logic                 cell_load;
    logic                 out_load;

    tad_cfg_regs u_cfg_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (cfg_write_enable),
        .index        (cfg_index),
        .data         (cfg_data),
        .cfg          (cfg)
    );

    tad_decode u_decode
    (
        .cur_cell   (cell_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign cell_fire = cell_valid_reg && (!emit || out_free);
    assign out_load  = cell_fire && emit;
    assign cell_load = !cell_valid_reg || cell_fire;
    assign in_stall  = !cell_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= tad_pkg::STATE_RESET;
        end
        else
        begin
            if (cell_load)
            begin
                cell_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= out_load;
            end
            if (cell_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_load && in_valid)
        begin
            cell_reg <= in_data;
        end
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_wide_sets_skip: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (result.width_bit_low || result.width_bit_high)
        && !cfg.forty_column |=> state_reg.skip_pending)
        else $error("wide cell on 80-column screen did not arm skip");

    a_drop_clears_skip: assert property (@(posedge clk) disable iff (!rst_n)
        cell_fire && !emit |=> !state_reg.skip_pending)
        else $error("dropped cell left skip pending");

    a_drop_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        cell_fire && !emit && !out_valid_reg |=> !out_valid_reg)
        else $error("dropped cell produced output");

    a_stall_needs_cell: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> cell_valid_reg && emit && out_valid_reg && out_stall)
        else $error("input stalled without a blocked cell");

endmodule

FILE: tb/text_attribute_decoder_tb.sv
`timescale 1ns / 1ps

module text_attribute_decoder_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_SLACK = 6;
    localparam int PHASES      = 8;
    localparam int PHASE_CELLS = 220;

    localparam int unsigned ADDR_W      = tad_pkg::ADDR_W;
    localparam int unsigned ATTR_W      = tad_pkg::ATTR_W;
    localparam int unsigned PEN_W       = tad_pkg::PEN_W;
    localparam int unsigned CFG_DATA_W  = tad_pkg::CFG_DATA_W;
    localparam int unsigned CFG_INDEX_W = tad_pkg::CFG_INDEX_W;

    class cell_tracker;
        tad_pkg::cfg_t        cfg;
        tad_pkg::attr_state_t st;
        tad_pkg::cell_out_t   pending_cells[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned dropped;
        int unsigned cursor_hits;
        int unsigned row_starts;
        int unsigned cells_in;

        function new();
            cfg         = '0;
            st          = tad_pkg::STATE_RESET;
            mismatches  = 0;
            checked     = 0;
            dropped     = 0;
            cursor_hits = 0;
            row_starts  = 0;
            cells_in    = 0;
        endfunction

        function void set_register(tad_pkg::cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                tad_pkg::CFG_FORTY_COLUMN:   cfg.forty_column   = v[0];
                tad_pkg::CFG_CURSOR_ENABLE:  cfg.cursor_enable  = v[0];
                tad_pkg::CFG_CURSOR_ADDRESS: cfg.cursor_address = v[ADDR_W-1:0];
                default: ;
            endcase
        endfunction

        function void load_pens(logic [ATTR_W-1:0] a);
            st.fg        = a[2:0];
            st.bg        = a[5:3];
            st.underline = a[6];
            st.flash     = a[7];
        endfunction

        function void decode_cell(tad_pkg::cell_in_t c);
            tad_pkg::cell_out_t  r;
            tad_pkg::attr_cmd_t  cmd;
            cells_in++;
            if (c.row_start)
            begin
                st           = tad_pkg::STATE_RESET;
                st.wide_low  = cfg.forty_column;
                st.wide_high = cfg.forty_column;
                row_starts++;
            end
            if (st.skip_pending)
            begin
                st.skip_pending = 1'b0;
                dropped++;
                return;
            end
            if (c.attr_byte[2:0] == c.attr_byte[5:3])
            begin
                cmd = tad_pkg::attr_cmd_t'(c.attr_byte[7:6]);
                case (cmd)
                    tad_pkg::CMD_BLANK:
                    begin
                        st.fg        = tad_pkg::PEN_BLACK;
                        st.bg        = tad_pkg::PEN_BLACK;
                        st.underline = 1'b0;
                        st.flash     = 1'b0;
                    end
                    tad_pkg::CMD_WIDE:
                    begin
                        st.wide_low  = c.attr_byte[0];
                        st.wide_high = c.attr_byte[1];
                        if (c.next_attr_byte != tad_pkg::ATTR_NONE)
                            load_pens(c.next_attr_byte);
                    end
                    default: ;
                endcase
            end
            else
            begin
                load_pens(c.attr_byte);
                st.wide_low  = cfg.forty_column;
                st.wide_high = cfg.forty_column;
            end
            r.code_out       = c.char_code;
            r.address_out    = c.cell_address;
            r.foreground     = st.fg;
            r.background     = st.bg;
            r.underline_on   = st.underline;
            r.blink_on       = st.flash;
            r.width_bit_low  = st.wide_low;
            r.width_bit_high = st.wide_high;
            r.cursor_here    = cfg.cursor_enable && (c.cell_address == cfg.cursor_address);
            if (r.cursor_here)
                cursor_hits++;
            pending_cells.push_back(r);
            if ((st.wide_low || st.wide_high) && !cfg.forty_column)
                st.skip_pending = 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned addr, int unsigned got,
                           int unsigned want);
            if (got != want)
                report($sformatf("cell at %0d: %s is %0d, expected %0d", addr, name, got, want));
        endtask

        task check_cell(tad_pkg::cell_out_t got);
            tad_pkg::cell_out_t want;
            int unsigned        at;
            if (pending_cells.size() == 0)
            begin
                report($sformatf("unexpected cell at %0d", got.address_out));
                return;
            end
            want = pending_cells.pop_front();
            at   = 32'(want.address_out);
            checked++;
            compare_field("code_out", at, 32'(got.code_out), 32'(want.code_out));
            compare_field("address_out", at, 32'(got.address_out), 32'(want.address_out));
            compare_field("foreground", at, 32'(got.foreground), 32'(want.foreground));
            compare_field("background", at, 32'(got.background), 32'(want.background));
            compare_field("underline_on", at, 32'(got.underline_on),
                          32'(want.underline_on));
            compare_field("blink_on", at, 32'(got.blink_on), 32'(want.blink_on));
            compare_field("width_bit_low", at, 32'(got.width_bit_low),
                          32'(want.width_bit_low));
            compare_field("width_bit_high", at, 32'(got.width_bit_high),
                          32'(want.width_bit_high));
            compare_field("cursor_here", at, 32'(got.cursor_here), 32'(want.cursor_here));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    tad_pkg::cell_in_t      in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    tad_pkg::cell_out_t     out_data;
    logic                   cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = tad_pkg::CFG_FORTY_COLUMN;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int unsigned cycles = 0;

    cell_tracker tracker = new();

    text_attribute_decoder dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // handshake signals are stable from the falling edge to the next rising edge
    always @(negedge clk)
        if (rst_n && out_valid && !out_stall)
            tracker.check_cell(out_data);

    task automatic send_cell(tad_pkg::cell_in_t c);
        logic taken;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        tracker.decode_cell(c);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.pending_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_config(logic forty, logic enable, logic [ADDR_W-1:0] addr);
        cfg_write_enable <= 1'b1;
        cfg_index        <= tad_pkg::CFG_FORTY_COLUMN;
        cfg_data         <= CFG_DATA_W'(forty);
        @(posedge clk);
        cfg_index <= tad_pkg::CFG_CURSOR_ENABLE;
        cfg_data  <= CFG_DATA_W'(enable);
        @(posedge clk);
        cfg_index <= tad_pkg::CFG_CURSOR_ADDRESS;
        cfg_data  <= addr;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        tracker.set_register(tad_pkg::CFG_FORTY_COLUMN, CFG_DATA_W'(forty));
        tracker.set_register(tad_pkg::CFG_CURSOR_ENABLE, CFG_DATA_W'(enable));
        tracker.set_register(tad_pkg::CFG_CURSOR_ADDRESS, addr);
    endtask

    task automatic set_mode(int mode);
        case (mode)
            1:       begin idle_pct = 62; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 62; end
            3:       begin idle_pct = 14; stall_pct = 14; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    function automatic tad_pkg::cell_in_t make_cell(logic rs, logic [7:0] code,
                                                    logic [7:0] attr, logic [7:0] next,
                                                    logic [ADDR_W-1:0] addr);
        tad_pkg::cell_in_t c;
        c.row_start      = rs;
        c.char_code      = code;
        c.attr_byte      = attr;
        c.next_attr_byte = next;
        c.cell_address   = addr;
        return c;
    endfunction

    // commands are weighted up since a plain random byte rarely has fg equal to bg
    function automatic logic [ATTR_W-1:0] pick_attr();
        logic [PEN_W-1:0]   pen;
        tad_pkg::attr_cmd_t cmd;
        int                 kind;
        kind = $urandom_range(9);
        pen  = PEN_W'($urandom);
        cmd  = tad_pkg::attr_cmd_t'($urandom_range(3));
        if (kind < 4)
            return ATTR_W'($urandom);
        if (kind == 8)
            return tad_pkg::ATTR_NONE;
        if (kind == 9)
            cmd = tad_pkg::CMD_WIDE;
        return {cmd, pen, pen};
    endfunction

    task automatic send_row(int len, logic [ADDR_W-1:0] base, logic with_start);
        logic [ATTR_W-1:0] attrs[];
        attrs = new[len + 1];
        foreach (attrs[i])
            attrs[i] = pick_attr();
        for (int i = 0; i < len; i++)
            send_cell(make_cell(with_start && (i == 0), 8'($urandom), attrs[i], attrs[i + 1],
                                base + ADDR_W'(i)));
    endtask

    initial
    begin
        int                sent;
        int                len;
        int                pick;
        logic              paused;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] cur;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cells ahead of any row start run on the reset state
        send_cell(make_cell(1'b0, 8'h00, 8'h00, 8'h00, 11'd0));
        send_cell(make_cell(1'b0, 8'h20, 8'h40, 8'hFF, 11'd1));
        wait_idle();

        write_config(1'b0, 1'b1, 11'h7FF);
        send_cell(make_cell(1'b1, 8'hFF, 8'hFF, 8'hFF, 11'h7FF));
        send_cell(make_cell(1'b0, 8'h41, 8'h12, 8'h80, 11'd0));
        send_cell(make_cell(1'b0, 8'h42, 8'h80, 8'hC9, 11'd1));
        send_cell(make_cell(1'b0, 8'h43, 8'hC9, 8'h00, 11'd2));
        send_cell(make_cell(1'b1, 8'h44, 8'h3A, 8'hC0, 11'd3));
        send_cell(make_cell(1'b0, 8'h45, 8'hC0, 8'hA5, 11'd4));
        send_cell(make_cell(1'b0, 8'h46, 8'h47, 8'hB8, 11'd5));
        send_cell(make_cell(1'b0, 8'h47, 8'hB8, 8'hDB, 11'd6));
        send_cell(make_cell(1'b0, 8'h48, 8'hDB, 8'h00, 11'd7));
        send_cell(make_cell(1'b0, 8'h49, 8'h80, 8'h52, 11'd8));
        send_cell(make_cell(1'b0, 8'h4A, 8'h52, 8'h00, 11'd9));
        wait_idle();

        write_config(1'b1, 1'b1, 11'd0);
        send_cell(make_cell(1'b1, 8'h00, 8'h00, 8'hC2, 11'h7FF));
        send_cell(make_cell(1'b0, 8'h61, 8'hC2, 8'h7E, 11'd0));
        send_cell(make_cell(1'b0, 8'h62, 8'h3F, 8'h80, 11'd1));
        send_cell(make_cell(1'b0, 8'h63, 8'h80, 8'hFF, 11'd2));
        send_cell(make_cell(1'b0, 8'hAA, 8'hFF, 8'h00, 11'h7FF));
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       cur = 11'd0;
                1, 3:    cur = 11'h7FF;
                default: cur = ADDR_W'($urandom);
            endcase
            write_config(p[0] ^ p[2], (p < 2) ? 1'b1 : (p < 4) ? 1'b0 : 1'($urandom), cur);
            set_mode(p % 4);
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_CELLS)
            begin
                if (!paused && sent >= PHASE_CELLS / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                len  = ($urandom_range(9) == 0) ? 80 : $urandom_range(1, 40);
                if ($urandom_range(2) == 0)
                    base = tracker.cfg.cursor_address - ADDR_W'($urandom_range(len - 1));
                else
                    base = ADDR_W'($urandom);
                if (pick < 15)
                begin
                    send_cell(make_cell(1'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom), ADDR_W'($urandom)));
                    sent++;
                end
                else
                begin
                    // a row without its start cell continues whatever state is left
                    send_row(len, base, pick >= 25);
                    sent += len;
                end
            end
            wait_idle();
        end

        $display("covered %0d cells in %0d phases: %0d results checked, %0d dropped",
                 tracker.cells_in, PHASES, tracker.checked, tracker.dropped);
        $display("row starts %0d, cursor matches %0d", tracker.row_starts, tracker.cursor_hits);
        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
